// ===== rtl/rksc_pkg.sv =====
// shared constants and codes for the rotary knob settings controller
`default_nettype none

package rksc_pkg;

   localparam int NUM_PANELS = 4;
   localparam int PANEL_W    = 3;

   localparam int LPT_W = 8;
   localparam int QNH_W = 11;
   localparam int HDG_W = 9;
   localparam int BRT_W = 7;

   localparam logic [QNH_W-1:0] QNH_MIN   = 11'd950;
   localparam logic [QNH_W-1:0] QNH_MAX   = 11'd1050;
   localparam logic [QNH_W-1:0] QNH_RESET = 11'd1013;
   localparam logic [HDG_W-1:0] HDG_LAST  = 9'd359;
   localparam logic [BRT_W-1:0] BRT_MIN   = 7'd10;
   localparam logic [BRT_W-1:0] BRT_MAX   = 7'd100;
   localparam logic [BRT_W-1:0] BRT_STEP  = 7'd5;
   localparam logic [LPT_W-1:0] LPT_RESET = 8'd80;

   localparam logic [PANEL_W-1:0] ALT_PANEL_RESET = 3'd1;
   localparam logic [PANEL_W-1:0] HDG_PANEL_RESET = 3'd2;

   // encoder phase codes, {a, b}
   localparam logic [1:0] AB_REST = 2'b11;
   localparam logic [1:0] AB_UP   = 2'b01;
   localparam logic [1:0] AB_DOWN = 2'b10;

   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LONG_PRESS = 2'd0,
      CSR_ALT_PANEL  = 2'd1,
      CSR_HDG_PANEL  = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

// ===== rtl/rksc_if.sv =====
// valid/ready channel interfaces for poll items and result items
`default_nettype none

interface rksc_req_if;
   logic valid;
   logic ready;
   logic enc_a;
   logic enc_b;
   logic button_level;
   logic read_failed;

   modport source (output valid, output enc_a, output enc_b, output button_level,
                   output read_failed, input ready);
   modport sink   (input valid, input enc_a, input enc_b, input button_level,
                   input read_failed, output ready);
endinterface

interface rksc_rsp_if import rksc_pkg::*;;
   logic               valid;
   logic               ready;
   logic               error;
   logic               redraw;
   logic [PANEL_W-1:0] panel_now;
   logic               settings_mode;
   logic [QNH_W-1:0]   qnh_out;
   logic [HDG_W-1:0]   heading_out;
   logic [BRT_W-1:0]   brightness_out;

   modport source (output valid, output error, output redraw, output panel_now,
                   output settings_mode, output qnh_out, output heading_out,
                   output brightness_out, input ready);
   modport sink   (input valid, input error, input redraw, input panel_now,
                   input settings_mode, input qnh_out, input heading_out,
                   input brightness_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/rotary_knob_settings_controller.sv =====
// top level: rotary encoder and push button poll handler with settings adjust
// the result item is registered on the edge that accepts the poll item
// throughput: one item per cycle; the single result register is refilled in the same
//   cycle it is drained, so req ready only drops while a result waits and rsp is stalled
// reset (synchronous, active high): not primed, button released, panel 0, view mode,
//   qnh 1013, heading 0, brightness 100, long press 80 polls, altimeter 1, compass 2
`default_nettype none

module rotary_knob_settings_controller import rksc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rksc_req_if.sink                   req_chan,
   rksc_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [LPT_W-1:0]   long_press_ff;
   logic [PANEL_W-1:0] alt_panel_ff;
   logic [PANEL_W-1:0] hdg_panel_ff;

   // knob and button state
   logic               primed_ff,      primed_in;
   logic [1:0]         prev_ab_ff,     prev_ab_in;
   logic               prev_button_ff, prev_button_in;
   logic [LPT_W-1:0]   hold_count_ff,  hold_count_in;
   logic               long_done_ff,   long_done_in;
   logic [PANEL_W-1:0] panel_ff,       panel_in;
   logic               adjust_ff,      adjust_in;
   logic [QNH_W-1:0]   qnh_ff,         qnh_in;
   logic [HDG_W-1:0]   heading_ff,     heading_in;
   logic [BRT_W-1:0]   bright_ff,      bright_in;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_error_ff;
   logic               rsp_redraw_ff;
   logic [PANEL_W-1:0] rsp_panel_ff;
   logic               rsp_mode_ff;
   logic [QNH_W-1:0]   rsp_qnh_ff;
   logic [HDG_W-1:0]   rsp_heading_ff;
   logic [BRT_W-1:0]   rsp_bright_ff;

   logic               accept;
   logic               error_in;
   logic               redraw_in;
   logic [1:0]         ab;
   logic               step_up;
   logic               step_down;
   logic [LPT_W-1:0]   hold_cap;
   logic [QNH_W-1:0]   qnh_step;
   logic [HDG_W-1:0]   heading_step;
   logic [BRT_W:0]     bright_plus;
   logic [BRT_W-1:0]   bright_step;
   logic [PANEL_W-1:0] panel_next;

   // take a poll whenever the result register is empty or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign ab = {req_chan.enc_a, req_chan.enc_b};

   // a detent counts only when it lands on rest from one of the two side phases
   assign step_up   = adjust_ff && (ab == AB_REST) && (prev_ab_ff == AB_UP);
   assign step_down = adjust_ff && (ab == AB_REST) && (prev_ab_ff == AB_DOWN);

   // qnh: saturating step inside 950..1050, then clamp
   always_comb begin
      qnh_step = qnh_ff;
      if (step_up) begin
         if (qnh_ff < QNH_MAX) qnh_step = qnh_ff + 11'd1;
      end else begin
         if (qnh_ff > QNH_MIN) qnh_step = qnh_ff - 11'd1;
      end
      if (qnh_step < QNH_MIN) qnh_step = QNH_MIN;
      if (qnh_step > QNH_MAX) qnh_step = QNH_MAX;
   end

   // heading bug: wraps around the compass rose
   always_comb begin
      if (step_up) begin
         heading_step = (heading_ff == HDG_LAST) ? '0 : heading_ff + 9'd1;
      end else begin
         heading_step = (heading_ff == '0) ? HDG_LAST : heading_ff - 9'd1;
      end
   end

   // brightness: steps of five, clamped at both ends
   assign bright_plus = {1'b0, bright_ff} + {1'b0, BRT_STEP};
   always_comb begin
      if (step_up) begin
         bright_step = (bright_plus > {1'b0, BRT_MAX}) ? BRT_MAX : bright_plus[BRT_W-1:0];
      end else begin
         bright_step = (bright_ff < BRT_MIN + BRT_STEP) ? BRT_MIN : bright_ff - BRT_STEP;
      end
   end

   // hold counter stops one past the long press count, capped at its full range
   assign hold_cap = (long_press_ff == '1) ? long_press_ff : long_press_ff + 8'd1;

   assign panel_next = (panel_ff == PANEL_W'(NUM_PANELS - 1)) ? '0 : panel_ff + 3'd1;

   // next state and result fields for the poll at the input
   always_comb begin
      primed_in      = primed_ff;
      prev_ab_in     = prev_ab_ff;
      prev_button_in = prev_button_ff;
      hold_count_in  = hold_count_ff;
      long_done_in   = long_done_ff;
      panel_in       = panel_ff;
      adjust_in      = adjust_ff;
      qnh_in         = qnh_ff;
      heading_in     = heading_ff;
      bright_in      = bright_ff;
      error_in       = 1'b0;
      redraw_in      = 1'b0;

      if (req_chan.read_failed) begin
         // rejected poll leaves everything alone
         error_in = 1'b1;
      end else if (!primed_ff) begin
         // first good poll only captures the levels
         primed_in      = 1'b1;
         prev_ab_in     = ab;
         prev_button_in = req_chan.button_level;
      end else begin
         if (step_up || step_down) begin
            redraw_in = 1'b1;
            // altimeter wins when both panel indices point at the same panel
            if (panel_ff == alt_panel_ff) begin
               qnh_in = qnh_step;
            end else if (panel_ff == hdg_panel_ff) begin
               heading_in = heading_step;
            end else begin
               bright_in = bright_step;
            end
         end
         prev_ab_in = ab;

         if (!req_chan.button_level) begin
            // held: count up, toggle settings mode once per hold
            hold_count_in = (hold_count_ff < hold_cap) ? hold_count_ff + 8'd1 : hold_count_ff;
            if ((hold_count_in >= long_press_ff) && !long_done_ff) begin
               adjust_in    = !adjust_ff;
               long_done_in = 1'b1;
               redraw_in    = 1'b1;
            end
         end else if (!prev_button_ff) begin
            // release: a short press leaves settings mode or moves to the next panel
            if (!long_done_ff) begin
               if (adjust_ff) begin
                  adjust_in = 1'b0;
               end else begin
                  panel_in = panel_next;
               end
               redraw_in = 1'b1;
            end
            hold_count_in = '0;
            long_done_in  = 1'b0;
         end
         prev_button_in = req_chan.button_level;
      end
   end

   // configuration writes, out-of-range indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= LPT_RESET;
         alt_panel_ff  <= ALT_PANEL_RESET;
         hdg_panel_ff  <= HDG_PANEL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LONG_PRESS: long_press_ff <= csr_wdata[LPT_W-1:0];
            CSR_ALT_PANEL:  alt_panel_ff  <= csr_wdata[PANEL_W-1:0];
            CSR_HDG_PANEL:  hdg_panel_ff  <= csr_wdata[PANEL_W-1:0];
            default: ;
         endcase
      end
   end

   // knob state advances once per accepted poll
   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff      <= 1'b0;
         prev_ab_ff     <= 2'b00;
         prev_button_ff <= 1'b1;
         hold_count_ff  <= '0;
         long_done_ff   <= 1'b0;
         panel_ff       <= '0;
         adjust_ff      <= 1'b0;
         qnh_ff         <= QNH_RESET;
         heading_ff     <= '0;
         bright_ff      <= BRT_MAX;
      end else if (accept) begin
         primed_ff      <= primed_in;
         prev_ab_ff     <= prev_ab_in;
         prev_button_ff <= prev_button_in;
         hold_count_ff  <= hold_count_in;
         long_done_ff   <= long_done_in;
         panel_ff       <= panel_in;
         adjust_ff      <= adjust_in;
         qnh_ff         <= qnh_in;
         heading_ff     <= heading_in;
         bright_ff      <= bright_in;
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, shows the state after this poll
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_error_ff   <= error_in;
         rsp_redraw_ff  <= redraw_in;
         rsp_panel_ff   <= panel_in;
         rsp_mode_ff    <= adjust_in;
         rsp_qnh_ff     <= qnh_in;
         rsp_heading_ff <= heading_in;
         rsp_bright_ff  <= bright_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.error          = rsp_error_ff;
   assign rsp_chan.redraw         = rsp_redraw_ff;
   assign rsp_chan.panel_now      = rsp_panel_ff;
   assign rsp_chan.settings_mode  = rsp_mode_ff;
   assign rsp_chan.qnh_out        = rsp_qnh_ff;
   assign rsp_chan.heading_out    = rsp_heading_ff;
   assign rsp_chan.brightness_out = rsp_bright_ff;

endmodule

`default_nettype wire

// ===== tb/rotary_knob_settings_controller_test.sv =====
// self-checking testbench for the rotary knob settings controller
`default_nettype none

module rotary_knob_settings_controller_test;
   import rksc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // encoder phase with both channels low, not named in the package
   localparam logic [1:0] AB_BOTH_LOW = 2'b00;
   // register index that decodes to nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   // generous cap on the whole run, far above the slowest legal run
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [1:0] ab;
      logic       btn;
      logic       fail;
   } poll_item_type;

   typedef struct {
      logic               error;
      logic               redraw;
      logic [PANEL_W-1:0] panel;
      logic               settings;
      logic [QNH_W-1:0]   qnh;
      logic [HDG_W-1:0]   heading;
      logic [BRT_W-1:0]   brightness;
   } knob_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rksc_req_if req_bus ();
   rksc_rsp_if rsp_bus ();

   rotary_knob_settings_controller i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus.sink),
      .rsp_chan  (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // poll items waiting for the driver, expected result items in order
   poll_item_type   poll_queue[$];
   knob_result_type expected_results[$];
   poll_item_type   poll_on_bus;
   knob_result_type oldest_result;
   int              polls_queued = 0;
   int              mismatches = 0;
   int              cycle_count = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;

   // predicted configuration
   logic [7:0]         cfg_long_press;
   logic [PANEL_W-1:0] cfg_alt_panel;
   logic [PANEL_W-1:0] cfg_hdg_panel;

   // predicted controller state
   logic               knob_primed;
   logic [1:0]         knob_prev_ab;
   logic               knob_prev_btn;
   logic [7:0]         hold_ticks;
   logic               press_latched;
   logic [PANEL_W-1:0] shown_panel;
   logic               adjusting;
   logic [QNH_W-1:0]   qnh_val;
   logic [HDG_W-1:0]   hdg_val;
   logic [BRT_W-1:0]   brt_val;

   // advance the predicted state by one accepted poll item
   function automatic knob_result_type knob_step(poll_item_type p);
      knob_result_type r;
      logic            up;
      int              cap;
      r.error  = 1'b0;
      r.redraw = 1'b0;
      if (p.fail) begin
         // rejected poll: state untouched
         r.error = 1'b1;
      end else if (!knob_primed) begin
         // first good poll only captures the levels
         knob_primed   = 1'b1;
         knob_prev_ab  = p.ab;
         knob_prev_btn = p.btn;
      end else begin
         // detent counts only on a return to rest from one of the two side phases
         if (adjusting && p.ab == AB_REST &&
             (knob_prev_ab == AB_UP || knob_prev_ab == AB_DOWN)) begin
            up = (knob_prev_ab == AB_UP);
            if (shown_panel == cfg_alt_panel) begin
               // altimeter wins when both indices match
               if (up && qnh_val < QNH_MAX) qnh_val = qnh_val + 1'b1;
               else if (!up && qnh_val > QNH_MIN) qnh_val = qnh_val - 1'b1;
            end else if (shown_panel == cfg_hdg_panel) begin
               if (up) hdg_val = (hdg_val == HDG_LAST) ? '0 : hdg_val + 1'b1;
               else hdg_val = (hdg_val == '0) ? HDG_LAST : hdg_val - 1'b1;
            end else begin
               if (up) brt_val = (brt_val + BRT_STEP > BRT_MAX) ? BRT_MAX : brt_val + BRT_STEP;
               else brt_val = (brt_val < BRT_MIN + BRT_STEP) ? BRT_MIN : brt_val - BRT_STEP;
            end
            r.redraw = 1'b1;
         end
         knob_prev_ab = p.ab;

         if (!p.btn) begin
            // hold counter saturates one past the threshold, at most 255
            cap = int'(cfg_long_press) + 1;
            if (cap > 255) cap = 255;
            if (int'(hold_ticks) < cap) hold_ticks = hold_ticks + 1'b1;
            if (hold_ticks >= cfg_long_press && !press_latched) begin
               adjusting     = !adjusting;
               press_latched = 1'b1;
               r.redraw      = 1'b1;
            end
         end else if (!knob_prev_btn) begin
            // release: short press leaves settings mode or moves to the next panel
            if (!press_latched) begin
               if (adjusting) adjusting = 1'b0;
               else shown_panel = PANEL_W'((int'(shown_panel) + 1) % NUM_PANELS);
               r.redraw = 1'b1;
            end
            hold_ticks    = '0;
            press_latched = 1'b0;
         end
         knob_prev_btn = p.btn;
      end
      r.panel      = shown_panel;
      r.settings   = adjusting;
      r.qnh        = qnh_val;
      r.heading    = hdg_val;
      r.brightness = brt_val;
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // driver: predicts each accepted item, then offers the next one or idles
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) expected_results.push_back(knob_step(poll_on_bus));
         if (!req_bus.valid || req_bus.ready) begin
            if (poll_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               poll_on_bus          = poll_queue.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.enc_a        <= poll_on_bus.ab[1];
               req_bus.enc_b        <= poll_on_bus.ab[0];
               req_bus.button_level <= poll_on_bus.btn;
               req_bus.read_failed  <= poll_on_bus.fail;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each accepted result item against the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result item with nothing expected", $time);
               mismatches++;
            end else begin
               oldest_result = expected_results.pop_front();
               check_field("error", 32'(oldest_result.error), 32'(rsp_bus.error));
               check_field("redraw", 32'(oldest_result.redraw), 32'(rsp_bus.redraw));
               check_field("panel_now", 32'(oldest_result.panel), 32'(rsp_bus.panel_now));
               check_field("settings_mode", 32'(oldest_result.settings),
                           32'(rsp_bus.settings_mode));
               check_field("qnh_out", 32'(oldest_result.qnh), 32'(rsp_bus.qnh_out));
               check_field("heading_out", 32'(oldest_result.heading),
                           32'(rsp_bus.heading_out));
               check_field("brightness_out", 32'(oldest_result.brightness),
                           32'(rsp_bus.brightness_out));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rotary_knob_settings_controller: mismatch");
         $finish;
      end
   end

   task automatic queue_poll(logic [1:0] ab, logic btn, logic fail);
      poll_queue.push_back('{ab: ab, btn: btn, fail: fail});
      polls_queued++;
   endtask

   // good poll, now and then preceded by a failed read with random levels
   task automatic queue_good_poll(logic [1:0] ab, logic btn);
      if ($urandom_range(24) == 0)
         queue_poll(2'($urandom_range(3)), 1'($urandom_range(1)), 1'b1);
      queue_poll(ab, btn, 1'b0);
   endtask

   // one detent, either the full quadrature cycle or the short side-and-back form
   task automatic queue_detent(logic up, logic btn);
      if ($urandom_range(1)) begin
         queue_good_poll(up ? AB_DOWN : AB_UP, btn);
         queue_good_poll(AB_BOTH_LOW, btn);
      end
      queue_good_poll(up ? AB_UP : AB_DOWN, btn);
      queue_good_poll(AB_REST, btn);
   endtask

   // random sessions: mostly well-formed turns and presses, some raw noise
   task automatic queue_random_polls(int budget);
      int stop_at;
      int pick;
      int n;
      int longest;
      logic up;
      stop_at = polls_queued + budget;
      while (polls_queued < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            // turn, sometimes far enough to hit the clamps or wrap
            n  = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            up = 1'($urandom_range(1));
            repeat (n) queue_detent(up, 1'b1);
         end else if (pick < 55) begin
            // long press, held a few polls past the threshold
            n = int'(cfg_long_press) + $urandom_range(3);
            if (n == 0) n = 1;
            repeat (n) queue_good_poll(AB_REST, 1'b0);
            queue_good_poll(AB_REST, 1'b1);
         end else if (pick < 75) begin
            // short press, released before the threshold where possible
            longest = (cfg_long_press > 1) ? int'(cfg_long_press) - 1 : 1;
            if (longest > 10) longest = 10;
            repeat ($urandom_range(1, longest)) queue_good_poll(AB_REST, 1'b0);
            queue_good_poll(AB_REST, 1'b1);
         end else if (pick < 85) begin
            // turning while the button is held
            repeat ($urandom_range(1, 4)) queue_detent(1'($urandom_range(1)), 1'b0);
            queue_good_poll(AB_REST, 1'b1);
         end else begin
            repeat ($urandom_range(1, 6))
               queue_poll(2'($urandom_range(3)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
         end
      end
   endtask

   // returns right after a rising edge once everything has come back
   task automatic wait_until_drained();
      while (poll_queue.size() != 0 || req_bus.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // called just after a rising edge; the write lands on the next one
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_LONG_PRESS: cfg_long_press = data;
         CSR_ALT_PANEL:  cfg_alt_panel = data[PANEL_W-1:0];
         CSR_HDG_PANEL:  cfg_hdg_panel = data[PANEL_W-1:0];
         default: ;
      endcase
   endtask

   // new settings while idle, then a batch of random polls
   task automatic run_setting(logic [7:0] lp, logic [PANEL_W-1:0] alt,
                              logic [PANEL_W-1:0] hdg, int budget);
      wait_until_drained();
      csr_write(CSR_LONG_PRESS, lp);
      // junk above the panel field must be dropped
      csr_write(CSR_ALT_PANEL, {5'($urandom_range(31)), alt});
      csr_write(CSR_HDG_PANEL, {5'($urandom_range(31)), hdg});
      if ($urandom_range(1)) csr_write(CSR_SPARE, 8'($urandom_range(255)));
      csr_we <= 1'b0;
      queue_random_polls(budget);
   endtask

   initial begin
      // every input known from time zero
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.enc_a        = 1'b0;
      req_bus.enc_b        = 1'b0;
      req_bus.button_level = 1'b1;
      req_bus.read_failed  = 1'b0;
      rsp_bus.ready        = 1'b0;

      // predicted state after reset
      cfg_long_press = LPT_RESET;
      cfg_alt_panel  = ALT_PANEL_RESET;
      cfg_hdg_panel  = HDG_PANEL_RESET;
      knob_primed    = 1'b0;
      knob_prev_ab   = '0;
      knob_prev_btn  = 1'b1;
      hold_ticks     = '0;
      press_latched  = 1'b0;
      shown_panel    = '0;
      adjusting      = 1'b0;
      qnh_val        = QNH_RESET;
      hdg_val        = '0;
      brt_val        = BRT_MAX;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 33;
      recv_idle_pct = 76;

      // reset settings: failed read before priming, priming, a detent outside
      // settings mode, a short press to the altimeter, a failed read with both channels low
      queue_poll(AB_REST, 1'b0, 1'b1);
      queue_poll(AB_UP, 1'b1, 1'b0);
      queue_poll(AB_REST, 1'b1, 1'b0);
      queue_poll(AB_REST, 1'b0, 1'b0);
      queue_poll(AB_REST, 1'b1, 1'b0);
      queue_poll(AB_BOTH_LOW, 1'b1, 1'b1);

      // two-poll long press on the altimeter panel
      wait_until_drained();
      csr_write(CSR_LONG_PRESS, 8'd2);
      csr_write(CSR_SPARE, 8'($urandom_range(255)));
      csr_we <= 1'b0;
      queue_poll(AB_REST, 1'b0, 1'b0);
      queue_poll(AB_REST, 1'b0, 1'b0);
      queue_poll(AB_REST, 1'b1, 1'b0);
      // qnh up, down, then a return from both-low that must be ignored
      queue_poll(AB_UP, 1'b1, 1'b0);
      queue_poll(AB_REST, 1'b1, 1'b0);
      queue_poll(AB_DOWN, 1'b1, 1'b0);
      queue_poll(AB_REST, 1'b1, 1'b0);
      queue_poll(AB_BOTH_LOW, 1'b1, 1'b0);
      queue_poll(AB_REST, 1'b1, 1'b0);
      // short press leaves settings mode, another moves to the compass, a long press re-enters it
      queue_poll(AB_REST, 1'b0, 1'b0);
      queue_poll(AB_REST, 1'b1, 1'b0);
      queue_poll(AB_REST, 1'b0, 1'b0);
      queue_poll(AB_REST, 1'b1, 1'b0);
      queue_poll(AB_REST, 1'b0, 1'b0);
      queue_poll(AB_REST, 1'b0, 1'b0);
      queue_poll(AB_REST, 1'b1, 1'b0);
      // heading wraps below zero and back
      queue_poll(AB_DOWN, 1'b1, 1'b0);
      queue_poll(AB_REST, 1'b1, 1'b0);
      queue_poll(AB_UP, 1'b1, 1'b0);
      queue_poll(AB_REST, 1'b1, 1'b0);

      // random part across several settings, extremes included
      run_setting(8'd3, 3'd1, 3'd2, 150);
      run_setting(8'd1, 3'd0, 3'd3, 100);

      send_idle_pct = 76;
      recv_idle_pct = 33;
      // same index for both: altimeter wins
      run_setting(LPT_RESET, 3'd2, 3'd2, 130);
      run_setting(8'd254, 3'd3, 3'd0, 120);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // panel indices beyond the panel count; a zero threshold makes every press a long press
      run_setting(8'd0, 3'd7, 3'd5, 80);
      run_setting(8'd255, 3'd6, 3'd1, 20);

      wait_until_drained();
      repeat (5) @(posedge clock);
      if (mismatches == 0) begin
         $display("rotary_knob_settings_controller: match");
      end else begin
         $display("rotary_knob_settings_controller: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/rksc_pkg.sv
rtl/rksc_if.sv
rtl/rotary_knob_settings_controller.sv
tb/rotary_knob_settings_controller_test.sv
